/* sv/mbs_pkg.sv */
package mbs_pkg;

   localparam int MAX_BOUNDARY_DEF = 32;
   localparam int TEXT_BYTES       = 32;
   localparam int RESULT_LIMIT     = 4;
   localparam int QUEUE_DEPTH      = 4;
   localparam int LEN_BITS         = 6;
   localparam int IDX_BITS         = 3;
   localparam int WORD_BITS        = 64;

   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;

   typedef enum logic [2:0] {
      KIND_HEADER      = 3'd0,
      KIND_HEADERS_END = 3'd1,
      KIND_CONTENT     = 3'd2,
      KIND_COMPLETE    = 3'd3,
      KIND_ABANDONED   = 3'd4,
      KIND_BODY_DONE   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      PH_PREAMBLE = 3'd0,
      PH_AFTER    = 3'd1,
      PH_HEADERS  = 3'd2,
      PH_CONTENT  = 3'd3,
      PH_DONE     = 3'd4
   } phase_type;

   typedef enum logic [IDX_BITS-1:0] {
      REG_WORD_0 = 3'd0,
      REG_WORD_1 = 3'd1,
      REG_WORD_2 = 3'd2,
      REG_WORD_3 = 3'd3,
      REG_LENGTH = 3'd4
   } reg_index_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } result_type;

   typedef struct packed {
      logic [2:0]                         count;
      result_type [RESULT_LIMIT-1:0]      item;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic bundle_type add_result(bundle_type bu, kind_type k, logic [7:0] d);
      if (bu.count < 3'(RESULT_LIMIT)) begin
         bu.item[bu.count[1:0]].kind = k;
         bu.item[bu.count[1:0]].data = d;
         bu.count = bu.count + 3'd1;
      end
      return bu;
   endfunction

endpackage

/* sv/mbs_front.sv */
module mbs_front #(
   parameter int MAX_BOUNDARY = mbs_pkg::MAX_BOUNDARY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,
   input  logic                          req_tlast,
   input  logic                          csr_valid,
   input  logic [mbs_pkg::IDX_BITS-1:0]  csr_index,
   input  logic [mbs_pkg::WORD_BITS-1:0] csr_data,
   input  mbs_pkg::queue_status_type     q_status,
   output logic                          push,
   output mbs_pkg::bundle_type           push_bundle
);
   import mbs_pkg::*;

   localparam int WIN = MAX_BOUNDARY + 4;
   localparam int LIM = (MAX_BOUNDARY < TEXT_BYTES) ? MAX_BOUNDARY : TEXT_BYTES;
   localparam int FW  = $clog2(WIN + 1);
   localparam int IW  = $clog2(WIN);

   logic [WORD_BITS-1:0] word_ff [4];
   logic [LEN_BITS-1:0]  length_ff;
   logic                 settle_ff;

   logic [7:0]    pat_ff  [WIN];
   logic [WIN-1:0] mask_ff;
   logic [FW-1:0] n_ff, d_ff;
   logic [IW-1:0] ix_d_ff, ix_d1_ff;
   logic [FW-1:0] n_in, d_in;
   logic [7:0]    pat_in  [WIN];
   logic [WIN-1:0] mask_in;

   logic [7:0]    w_ff [WIN];
   logic [7:0]    w_in [WIN];
   logic [7:0]    wsh  [WIN];
   logic [FW-1:0] fill_ff, fill_in;
   phase_type     phase_ff, phase_in;

   logic          accept;
   logic          tail_ok;
   bundle_type    bu;

   assign req_tready = !settle_ff && !q_status.full;
   assign accept     = req_tvalid && req_tready;

   // boundary pattern, newest byte at index 0
   always_comb begin
      logic [8*TEXT_BYTES-1:0] text;
      int idx;
      logic [4:0] ti;
      text = {word_ff[3], word_ff[2], word_ff[1], word_ff[0]};
      if (length_ff == '0) begin
         n_in = FW'(1);
      end else if (int'(length_ff) > LIM) begin
         n_in = FW'(LIM);
      end else begin
         n_in = FW'(length_ff);
      end
      d_in = n_in + FW'(2);
      for (int k = 0; k < WIN; k++) begin
         idx = int'(d_in) - 1 - k;
         ti  = 5'(idx - 2);
         mask_in[k] = (k < int'(d_in));
         if (k >= int'(d_in)) begin
            pat_in[k] = 8'h00;
         end else if (idx < 2) begin
            pat_in[k] = CHAR_DASH;
         end else begin
            pat_in[k] = text[8*ti +: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      pat_ff   <= pat_in;
      mask_ff  <= mask_in;
      n_ff     <= n_in;
      d_ff     <= d_in;
      ix_d_ff  <= IW'(d_in);
      ix_d1_ff <= IW'(d_in + FW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff[0] <= '0;
         word_ff[1] <= '0;
         word_ff[2] <= '0;
         word_ff[3] <= '0;
         length_ff  <= LEN_BITS'(1);
         settle_ff  <= 1'b1;
      end else begin
         settle_ff <= csr_valid;
         if (csr_valid) begin
            case (csr_index)
               REG_WORD_0: word_ff[0] <= csr_data;
               REG_WORD_1: word_ff[1] <= csr_data;
               REG_WORD_2: word_ff[2] <= csr_data;
               REG_WORD_3: word_ff[3] <= csr_data;
               REG_LENGTH: length_ff  <= csr_data[LEN_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      wsh[0] = req_tdata;
      for (int k = 1; k < WIN; k++) begin
         wsh[k] = w_ff[k-1];
      end
      tail_ok = 1'b1;
      for (int k = 0; k < WIN; k++) begin
         if (mask_ff[k] && wsh[k] != pat_ff[k]) begin
            tail_ok = 1'b0;
         end
      end
   end

   always_comb begin
      logic [FW-1:0] f, tot;
      logic [7:0]    b, a;
      logic          held, hold_new;
      w_in     = w_ff;
      fill_in  = fill_ff;
      phase_in = phase_ff;
      bu       = '0;
      b        = req_tdata;
      a        = w_ff[0];
      f        = '0;
      tot      = '0;
      held     = 1'b0;
      hold_new = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_PREAMBLE: begin
               f   = (fill_ff > d_ff - FW'(1)) ? d_ff - FW'(1) : fill_ff;
               tot = f + FW'(1);
               w_in = wsh;
               if (tot >= d_ff && tail_ok) begin
                  phase_in = PH_AFTER;
                  fill_in  = '0;
               end else begin
                  fill_in = tot;
               end
            end
            PH_AFTER: begin
               w_in = wsh;
               if (fill_ff == '0) begin
                  fill_in = FW'(1);
                  if (!(b == CHAR_DASH || b == CHAR_CR)) begin
                     phase_in = PH_HEADERS;
                     bu = add_result(bu, KIND_HEADER, b);
                  end
               end else if (a == CHAR_DASH && b == CHAR_DASH) begin
                  phase_in = PH_DONE;
                  fill_in  = '0;
               end else if (a == CHAR_CR && b == CHAR_LF) begin
                  phase_in = PH_HEADERS;
                  fill_in  = '0;
               end else begin
                  phase_in = PH_HEADERS;
                  fill_in  = FW'(2);
                  bu = add_result(bu, KIND_HEADER, a);
                  bu = add_result(bu, KIND_HEADER, b);
               end
            end
            PH_HEADERS: begin
               held = fill_ff >= FW'(3) && w_ff[2] == CHAR_CR && w_ff[1] == CHAR_LF &&
                      w_ff[0] == CHAR_CR;
               if (held && b == CHAR_LF) begin
                  bu = add_result(bu, KIND_HEADERS_END, 8'h00);
                  phase_in = PH_CONTENT;
                  fill_in  = '0;
               end else begin
                  if (held) begin
                     bu = add_result(bu, KIND_HEADER, CHAR_CR);
                  end
                  hold_new = b == CHAR_CR && fill_ff >= FW'(2) && w_ff[1] == CHAR_CR &&
                             w_ff[0] == CHAR_LF;
                  if (!hold_new) begin
                     bu = add_result(bu, KIND_HEADER, b);
                  end
                  w_in    = wsh;
                  fill_in = ((fill_ff > FW'(2)) ? FW'(2) : fill_ff) + FW'(1);
               end
            end
            PH_CONTENT: begin
               f   = (fill_ff > n_ff + FW'(3)) ? n_ff + FW'(3) : fill_ff;
               tot = f + FW'(1);
               w_in = wsh;
               if (tot >= d_ff && tail_ok) begin
                  if (tot == d_ff + FW'(2)) begin
                     if (!(wsh[ix_d1_ff] == CHAR_CR && wsh[ix_d_ff] == CHAR_LF)) begin
                        bu = add_result(bu, KIND_CONTENT, wsh[ix_d1_ff]);
                        bu = add_result(bu, KIND_CONTENT, wsh[ix_d_ff]);
                     end
                  end else if (tot == d_ff + FW'(1)) begin
                     bu = add_result(bu, KIND_CONTENT, wsh[ix_d_ff]);
                  end
                  bu = add_result(bu, KIND_COMPLETE, 8'h00);
                  phase_in = PH_AFTER;
                  fill_in  = '0;
               end else if (tot >= n_ff + FW'(4)) begin
                  // window full: release the oldest byte
                  bu = add_result(bu, KIND_CONTENT, wsh[ix_d1_ff]);
                  fill_in = tot - FW'(1);
               end else begin
                  fill_in = tot;
               end
            end
            default: phase_in = PH_DONE;
         endcase
         if (req_tlast) begin
            if (phase_in == PH_HEADERS || phase_in == PH_CONTENT) begin
               bu = add_result(bu, KIND_ABANDONED, 8'h00);
            end
            bu = add_result(bu, KIND_BODY_DONE, 8'h00);
            phase_in = PH_PREAMBLE;
            fill_in  = '0;
         end
      end
      if (csr_valid && csr_index == REG_LENGTH) begin
         phase_in = PH_PREAMBLE;
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREAMBLE;
         fill_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   assign push        = accept && bu.count != 3'd0;
   assign push_bundle = bu;

   a_after_fill: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_AFTER |-> fill_ff <= FW'(1))
      else $error("after-delimiter window holds more than one byte");
   a_header_fill: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADERS |-> fill_ff <= FW'(3))
      else $error("header window holds more than three bytes");
   a_end_pushes: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |-> push)
      else $error("last body byte produced no body-done result");

endmodule

/* sv/mbs_queue.sv */
module mbs_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mbs_pkg::bundle_type       push_bundle,
   input  logic                      pop,
   output mbs_pkg::bundle_type       head,
   output mbs_pkg::queue_status_type status
);
   import mbs_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   bundle_type      slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [PW:0]     count_ff;

   assign status.full  = count_ff == (PW+1)'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign head         = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + PW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + PW'(1);
         end
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("pop from empty queue");

endmodule

/* sv/mbs_back.sv */
module mbs_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mbs_pkg::bundle_type       head,
   input  mbs_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic [2:0]                rsp_tuser,
   output logic                      rsp_tlast
);
   import mbs_pkg::*;

   logic [1:0] idx_ff;
   logic       valid_ff;
   logic [7:0] data_ff;
   kind_type   kind_ff;
   logic       last_ff;
   logic       load;
   logic       at_last;

   assign load    = !q_status.empty && (!valid_ff || rsp_tready);
   assign at_last = ({1'b0, idx_ff} + 3'd1) == head.count;
   assign pop     = load && at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= at_last ? 2'd0 : idx_ff + 2'd1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= head.item[idx_ff].kind;
         data_ff <= head.item[idx_ff].data;
         last_ff <= at_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      load |-> {1'b0, idx_ff} < head.count)
      else $error("result index beyond bundle count");

endmodule

/* sv/multipart_boundary_splitter_top.sv */
// Multipart body splitter.
// Request channel (req_): one body byte per request, req_tlast on the last
// byte of a body. Response channel (rsp_): tdata carries a header or content
// byte, tuser the result kind (header byte, headers end, content byte, part
// complete, part abandoned, body done), tlast marks the final result caused
// by one request. Configuration (csr_): boundary text words 0..3, then the
// boundary length; writing the length restarts the parser in its preamble.
// One request is taken per cycle while the result queue has room. Results
// are written into the queue, then registered at the output, which drains one
// result per cycle while the receiver is ready; requests with several results
// set the long-run rate. The delimiter compare over the window is combinational.
// The request side stays ready while fewer than four bundles wait, so a
// stalled receiver holds the front back only once that queue is full.
// Reset clears the parser, the queue and the registers (length one); the
// request side is held not ready by a settle register after reset and after
// each configuration write while the boundary pattern is rebuilt.
module multipart_boundary_splitter_top #(
   parameter int MAX_BOUNDARY = mbs_pkg::MAX_BOUNDARY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] body_byte
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] data
   output logic [2:0]                    rsp_tuser,   // [2:0] kind
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mbs_pkg::IDX_BITS-1:0]  csr_index,
   input  logic [mbs_pkg::WORD_BITS-1:0] csr_data
);
   import mbs_pkg::*;

   logic             push, pop;
   bundle_type       push_bundle, head;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   mbs_front #(.MAX_BOUNDARY(MAX_BOUNDARY)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_status    (q_status),
      .push        (push),
      .push_bundle (push_bundle)
   );

   mbs_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .status      (q_status)
   );

   mbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* tb/sv/multipart_boundary_splitter_top_test.sv */
`timescale 1ns / 1ps

module multipart_boundary_splitter_top_test;
   import mbs_pkg::*;

   localparam int WIN_DEPTH = MAX_BOUNDARY_DEF + 4;
   localparam logic [IDX_BITS-1:0] REG_UNUSED = 3'd7;

   typedef struct {
      logic [7:0] body_byte;
      logic       body_end;
   } body_req_type;

   typedef struct {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } split_out_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;
   logic                 req_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [7:0]           rsp_tdata;
   logic [2:0]           rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [IDX_BITS-1:0]  csr_index;
   logic [WORD_BITS-1:0] csr_data;

   multipart_boundary_splitter_top uut (.*);

   // predictor state
   logic [7:0]  win [WIN_DEPTH];
   int          fill;
   phase_type   phase;
   logic [63:0] bword [4];
   logic [5:0]  blen;

   split_out_type step_out[$];
   split_out_type split_expect[$];
   body_req_type  body_pend[$];
   body_req_type  body_tmp[$];

   int  errors;
   int  queued;
   int  req_gap;
   int  rsp_gap;
   bit  quiet;
   byte btext [32];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("multipart_boundary_splitter_top regression: fail");
      $finish;
   end

   function automatic void put(kind_type k, logic [7:0] d);
      split_out_type r;
      if (step_out.size() < RESULT_LIMIT) begin
         r.kind = k;
         r.data = d;
         r.last = 1'b0;
         step_out.push_back(r);
      end
   endfunction

   function automatic int text_len();
      int n;
      n = blen;
      if (n < 1) n = 1;
      if (n > MAX_BOUNDARY_DEF) n = MAX_BOUNDARY_DEF;
      return n;
   endfunction

   function automatic logic [7:0] delim_at(int j);
      int i;
      i = j - 2;
      if (j < 2) return CHAR_DASH;
      return bword[i / 8][8 * (i % 8) +: 8];
   endfunction

   function automatic bit tail_delim(int total);
      int d;
      int base;
      d = 2 + text_len();
      if (total < d || total > WIN_DEPTH) return 1'b0;
      base = total - d;
      for (int j = 0; j < d; j++)
         if (win[base + j] != delim_at(j)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void keep_last(int n);
      if (fill > WIN_DEPTH) fill = WIN_DEPTH;
      if (fill > n) begin
         for (int i = 0; i < n; i++) win[i] = win[fill - n + i];
         fill = n;
      end
   endfunction

   function automatic void header_feed(logic [7:0] b);
      bit held;
      bit hold_new;
      keep_last(3);
      held = fill == 3 && win[0] == CHAR_CR && win[1] == CHAR_LF && win[2] == CHAR_CR;
      if (held && b == CHAR_LF) begin
         put(KIND_HEADERS_END, 8'd0);
         phase = PH_CONTENT;
         fill = 0;
         return;
      end
      if (held) put(KIND_HEADER, CHAR_CR);
      hold_new = b == CHAR_CR && fill >= 2 && win[fill - 2] == CHAR_CR
                 && win[fill - 1] == CHAR_LF;
      if (!hold_new) put(KIND_HEADER, b);
      keep_last(2);
      win[fill] = b;
      fill++;
   endfunction

   function automatic void preamble_feed(logic [7:0] b);
      keep_last(1 + text_len());
      win[fill] = b;
      fill++;
      if (tail_delim(fill)) begin
         phase = PH_AFTER;
         fill = 0;
      end
   endfunction

   function automatic void after_feed(logic [7:0] b);
      logic [7:0] a;
      keep_last(1);
      if (fill == 0) begin
         if (b == CHAR_DASH || b == CHAR_CR) begin
            win[0] = b;
            fill = 1;
         end else begin
            phase = PH_HEADERS;
            header_feed(b);
         end
         return;
      end
      a = win[0];
      fill = 0;
      if (a == CHAR_DASH && b == CHAR_DASH) begin
         phase = PH_DONE;
      end else if (a == CHAR_CR && b == CHAR_LF) begin
         phase = PH_HEADERS;
      end else begin
         phase = PH_HEADERS;
         header_feed(a);
         header_feed(b);
      end
   endfunction

   function automatic void content_feed(logic [7:0] b);
      int n;
      int total;
      int p;
      n = text_len();
      keep_last(3 + n);
      win[fill] = b;
      fill++;
      total = fill;
      if (tail_delim(total)) begin
         p = total - (2 + n);
         // drop the CRLF that sits right before the delimiter
         if (!(p == 2 && win[0] == CHAR_CR && win[1] == CHAR_LF))
            for (int j = 0; j < p; j++) put(KIND_CONTENT, win[j]);
         put(KIND_COMPLETE, 8'd0);
         phase = PH_AFTER;
         fill = 0;
      end else if (total >= 4 + n) begin
         put(KIND_CONTENT, win[0]);
         for (int j = 0; j < total - 1; j++) win[j] = win[j + 1];
         fill = total - 1;
      end
   endfunction

   function automatic void predict_split(logic [7:0] b, logic e);
      step_out.delete();
      case (phase)
         PH_PREAMBLE: preamble_feed(b);
         PH_AFTER:    after_feed(b);
         PH_HEADERS:  header_feed(b);
         PH_CONTENT:  content_feed(b);
         default:     phase = PH_DONE;
      endcase
      if (e) begin
         if (phase == PH_HEADERS || phase == PH_CONTENT) put(KIND_ABANDONED, 8'd0);
         put(KIND_BODY_DONE, 8'd0);
         phase = PH_PREAMBLE;
         fill = 0;
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) split_expect.push_back(step_out[i]);
   endfunction

   function automatic void apply_csr(logic [IDX_BITS-1:0] idx, logic [63:0] v);
      case (idx)
         REG_WORD_0: bword[0] = v;
         REG_WORD_1: bword[1] = v;
         REG_WORD_2: bword[2] = v;
         REG_WORD_3: bword[3] = v;
         REG_LENGTH: begin
            blen = v[5:0];
            fill = 0;
            phase = PH_PREAMBLE;
         end
         default: ;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_split(body_pend[0].body_byte, body_pend[0].body_end);
            void'(body_pend.pop_front());
         end
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (body_pend.size() > 0) begin
            // hold a request that is still waiting for ready
            if (!quiet && !(req_tvalid && !req_tready) && $urandom_range(0, 9) == 0) begin
               req_gap = $urandom_range(1, 12);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= body_pend[0].body_byte;
               req_tlast  <= body_pend[0].body_end;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      split_out_type x;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (split_expect.size() == 0) begin
               $error("unexpected result kind=%0d data=%0h", rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               x = split_expect.pop_front();
               if (rsp_tuser != x.kind) begin
                  $error("kind: expected %0d, actual %0d", x.kind, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata != x.data) begin
                  $error("data: expected %0h, actual %0h", x.data, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast != x.last) begin
                  $error("last_of_run: expected %0d, actual %0d", x.last, rsp_tlast);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_gap = $urandom_range(1, 12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(logic [IDX_BITS-1:0] idx, logic [63:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      forever begin
         @(posedge clock);
         if (csr_valid && csr_ready) break;
      end
      apply_csr(idx, v);
      csr_valid <= 1'b0;
   endtask

   task automatic set_boundary(int len_reg, bit printable);
      logic [63:0] w;
      for (int i = 0; i < 32; i++)
         btext[i] = printable ? byte'($urandom_range(8'h30, 8'h7a))
                              : byte'($urandom_range(0, 255));
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 8; i++) w[8 * i +: 8] = btext[8 * k + i];
         csr_write(reg_index_type'(k), w);
      end
      csr_write(REG_UNUSED, {$urandom, $urandom});
      csr_write(REG_LENGTH, 64'(len_reg));
   endtask

   function automatic void add(logic [7:0] b);
      body_req_type r;
      r.body_byte = b;
      r.body_end  = 1'b0;
      body_tmp.push_back(r);
   endfunction

   function automatic void add_str(string s);
      for (int i = 0; i < s.len(); i++) add(s[i]);
   endfunction

   function automatic void add_delim(int n);
      add(CHAR_DASH);
      add(CHAR_DASH);
      for (int i = 0; i < n; i++) add(btext[i]);
   endfunction

   function automatic void add_noise(int cnt);
      for (int i = 0; i < cnt; i++) begin
         case ($urandom_range(0, 5))
            0: add(CHAR_CR);
            1: add(CHAR_LF);
            2: add(CHAR_DASH);
            default: add(8'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   // close the staged body and queue it for the driver
   function automatic void ship(int cut);
      if (body_tmp.size() == 0) add(8'($urandom_range(0, 255)));
      if (cut > 0 && cut < body_tmp.size()) body_tmp = body_tmp[0:cut - 1];
      body_tmp[body_tmp.size() - 1].body_end = 1'b1;
      foreach (body_tmp[i]) body_pend.push_back(body_tmp[i]);
      queued += body_tmp.size();
      body_tmp.delete();
   endfunction

   task automatic random_body();
      int n;
      int parts;
      n = text_len();
      parts = $urandom_range(1, 3);
      add_noise($urandom_range(0, 4));
      for (int p = 0; p < parts; p++) begin
         add_delim(n);
         if ($urandom_range(0, 5) == 0) add_noise(2);
         else add_str("\r\n");
         for (int h = 0; h < $urandom_range(0, 2); h++) begin
            add_noise($urandom_range(1, 5));
            add_str("\r\n");
         end
         add_str("\r\n");
         add_noise($urandom_range(0, 8));
         if ($urandom_range(0, 2) != 0) add_str("\r\n");
      end
      add_delim(n);
      if ($urandom_range(0, 3) != 0) add_str("--");
      add_noise($urandom_range(0, 3));
      ship($urandom_range(0, 4) == 0 ? $urandom_range(1, body_tmp.size()) : 0);
   endtask

   task automatic wait_idle();
      while (body_pend.size() > 0 || req_tvalid || split_expect.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      int lens [7] = '{3, 1, 32, 0, 63, 7, 12};
      errors = 0;
      queued = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_WORD_0;
      csr_data = '0;
      bword = '{default: 64'd0};
      blen = 6'd1;
      fill = 0;
      phase = PH_PREAMBLE;
      win = '{default: 8'd0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_boundary(lens[0], 1'b1);
      // single and two byte bodies, extreme byte values
      add(8'hff); ship(0);
      add(8'h00); add(8'hff); ship(0);
      // closing delimiter right away, then ignored epilogue
      add_delim(3); add_str("--xy"); ship(0);
      // held dash followed by another byte starts headers
      add_delim(3); add_str("-a\r\n\r\nz"); ship(0);
      // held CR followed by a non-LF byte
      add_delim(3); add_str("\rq\r\n\r\nzz\r\n"); add_delim(3); add_str("--"); ship(0);
      // headers cut off by the body end
      add_delim(3); add_str("\r\nab\r"); ship(0);
      wait_idle();

      for (int ph = 1; ph < 7; ph++) begin
         quiet = ph == 6;
         set_boundary(lens[ph], $urandom_range(0, 1));
         do begin
            random_body();
         end while (queued < 72 * ph);
         wait_idle();
      end
      repeat (20) @(posedge clock);

      if (split_expect.size() > 0) begin
         $error("%0d expected results never arrived", split_expect.size());
         errors++;
      end
      if (errors == 0)
         $display("multipart_boundary_splitter_top regression: pass");
      else
         $display("multipart_boundary_splitter_top regression: fail");
      $finish;
   end

endmodule
